[sv/rpvg_pkg.sv]
// shared constants, types and the quarter-wave sine table of the polygon vertex generator
package rpvg_pkg;

	localparam int MAX_SIDES       = 64;
	localparam int SINE_TABLE_BITS = 8;

	localparam int COORD_W  = 20;
	localparam int SIDES_W  = 7;
	localparam int RADIUS_W = 19;

	localparam int QSTEPS     = 1 << SINE_TABLE_BITS;
	localparam int FULL_STEPS = 4 << SINE_TABLE_BITS;
	localparam int PHASE_W    = SINE_TABLE_BITS + 2;
	localparam int TURN_W     = SINE_TABLE_BITS + 3;
	localparam int DIV_CNT_W  = $clog2(TURN_W);
	localparam int LUT_W      = 17;
	localparam int LUT_IDX_W  = SINE_TABLE_BITS + 1;
	localparam int ACC_R_W    = SIDES_W + 1;

	localparam int PROD_W = RADIUS_W + LUT_W;
	localparam int OFF_W  = PROD_W + 1 - 15;
	localparam int SUM_W  = OFF_W + 2;

	localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN = -(1 << (COORD_W - 1));

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t                center_x;
		coord_t                center_y;
		logic [RADIUS_W-1:0]   radius;
		logic [SIDES_W-1:0]    sides;
		logic [PHASE_W-1:0]    step_q;
		logic [ACC_R_W-1:0]    step_r;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_PUSH
	} fe_state_t;

	typedef logic [QSTEPS:0][LUT_W-1:0] sine_lut_t;

	function automatic logic [LUT_W-1:0] sine_entry(int unsigned k);
		logic [63:0] ang;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		longint      v;
		ang  = (HALF_PI_Q30 * 64'(k) + 64'(QSTEPS / 2)) / 64'(QSTEPS);
		x    = ang;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 16384) >>> 15;
		if (v > 32768) begin
			v = 32768;
		end
		return LUT_W'(v);
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t t;
		for (int k = 0; k <= QSTEPS; k++) begin
			t[k] = sine_entry(k);
		end
		return t;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

[sv/rpvg_shape_if.sv]
// polygon request channel: centre, radius and side count
interface rpvg_shape_if import rpvg_pkg::*; ();
	logic                valid;
	logic                ready;
	coord_t              center_x;
	coord_t              center_y;
	logic [SIDES_W-1:0]  side_count;
	logic [RADIUS_W-1:0] radius;

	modport source (output valid, output center_x, output center_y, output side_count,
		output radius, input ready);
	modport sink (input valid, input center_x, input center_y, input side_count,
		input radius, output ready);
endinterface

[sv/rpvg_vertex_if.sv]
// vertex result channel
interface rpvg_vertex_if import rpvg_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t vertex_x;
	coord_t vertex_y;
	logic   last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

[sv/rpvg_front.sv]
// request front end: side count clamp and per-polygon angle step divider
module rpvg_front import rpvg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rpvg_shape_if.sink   shape,
	input  logic         q_full,
	output q_push_t      push
);

	fe_state_t             state_q;
	fe_state_t             state_d;
	logic [DIV_CNT_W-1:0]  cnt_q;
	coord_t                cx_q;
	coord_t                cy_q;
	logic [RADIUS_W-1:0]   rad_q;
	logic [SIDES_W-1:0]    sides_q;
	logic [TURN_W-1:0]     quo_q;
	logic [SIDES_W-1:0]    rem_q;

	logic [SIDES_W-1:0]    sides_clamped;
	logic [SIDES_W:0]      trial;
	logic                  trial_ge;
	logic                  div_step;
	logic                  accept;
	logic                  push_valid;

	assign sides_clamped = (shape.side_count > SIDES_W'(MAX_SIDES)) ?
		SIDES_W'(MAX_SIDES) : shape.side_count;
	assign trial    = {rem_q, quo_q[TURN_W-1]};
	assign trial_ge = trial >= {1'b0, sides_q};
	assign accept   = shape.valid && shape.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		shape.ready = 1'b0;
		push_valid  = 1'b0;
		div_step    = 1'b0;
		unique case (state_q)
			FE_IDLE: begin
				shape.ready = 1'b1;
				if (shape.valid && sides_clamped != '0) begin
					state_d = FE_DIV;
				end
			end
			FE_DIV: begin
				div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(TURN_W - 1)) begin
					state_d = FE_PUSH;
				end
			end
			FE_PUSH: begin
				push_valid = 1'b1;
				if (!q_full) begin
					state_d = FE_IDLE;
				end
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

	// long division of a full turn by the side count, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q    <= shape.center_x;
			cy_q    <= shape.center_y;
			rad_q   <= shape.radius;
			sides_q <= sides_clamped;
			quo_q   <= TURN_W'(FULL_STEPS);
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (div_step) begin
			cnt_q <= cnt_q + 1'b1;
			rem_q <= trial_ge ? SIDES_W'(trial - {1'b0, sides_q}) : trial[SIDES_W-1:0];
			quo_q <= {quo_q[TURN_W-2:0], trial_ge};
		end
	end

	assign push.valid         = push_valid;
	assign push.item.center_x = cx_q;
	assign push.item.center_y = cy_q;
	assign push.item.radius   = rad_q;
	assign push.item.sides    = sides_q;
	assign push.item.step_q   = quo_q[PHASE_W-1:0];
	assign push.item.step_r   = {rem_q, 1'b0};

endmodule

[sv/rpvg_queue.sv]
// two-entry queue of classified polygons between front end and vertex engine
module rpvg_queue import rpvg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t push,
	output logic    full,
	output q_head_t head,
	input  logic    pop
);

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full       = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.item  = entry_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

[sv/rpvg_back.sv]
// vertex engine: phase stepping, sine lookup, scaling and saturating placement
module rpvg_back import rpvg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  q_head_t       head,
	output logic          pop,
	rpvg_vertex_if.source vertex
);

	function automatic logic [LUT_W:0] phase_sine(logic [PHASE_W-1:0] p);
		logic [SINE_TABLE_BITS-1:0] r;
		logic [LUT_IDX_W-1:0]       idx;
		r   = p[SINE_TABLE_BITS-1:0];
		idx = p[SINE_TABLE_BITS] ? (LUT_IDX_W'(QSTEPS) - {1'b0, r}) : {1'b0, r};
		return {p[SINE_TABLE_BITS+1], SINE_LUT[idx]};
	endfunction

	function automatic coord_t place(coord_t center, logic [PROD_W-1:0] prod, logic neg);
		logic [PROD_W:0]          rounded;
		logic [OFF_W-1:0]         off;
		logic signed [SUM_W-1:0]  c_ext;
		logic signed [SUM_W-1:0]  o_ext;
		logic signed [SUM_W-1:0]  v;
		rounded = {1'b0, prod} + (PROD_W + 1)'(16384);
		off     = rounded[PROD_W:15];
		c_ext   = SUM_W'(center);
		o_ext   = $signed({2'b00, off});
		v       = neg ? (c_ext - o_ext) : (c_ext + o_ext);
		if (v > SUM_W'(COORD_MAX)) begin
			v = SUM_W'(COORD_MAX);
		end else if (v < SUM_W'(COORD_MIN)) begin
			v = SUM_W'(COORD_MIN);
		end
		return v[COORD_W-1:0];
	endfunction

	logic                busy_q;
	item_t               item_q;
	logic [SIDES_W-1:0]  idx_q;
	logic [PHASE_W-1:0]  ph_q;
	logic [ACC_R_W-1:0]  rr_q;

	logic                en;
	logic                issue;
	logic                last_now;
	logic [ACC_R_W:0]    sum_r;
	logic [ACC_R_W:0]    two_n;
	logic                wrap;

	logic                vld_s1;
	logic                last_s1;
	coord_t              cx_s1;
	coord_t              cy_s1;
	logic [RADIUS_W-1:0] rad_s1;
	logic [LUT_W:0]      sx_s1;
	logic [LUT_W:0]      sy_s1;

	logic                vld_s2;
	logic                last_s2;
	coord_t              cx_s2;
	coord_t              cy_s2;
	logic [PROD_W-1:0]   px_s2;
	logic [PROD_W-1:0]   py_s2;
	logic                nx_s2;
	logic                ny_s2;

	logic                vld_s3;
	logic                last_s3;
	coord_t              vx_s3;
	coord_t              vy_s3;

	assign en       = !vld_s3 || vertex.ready;
	assign issue    = busy_q && en;
	assign last_now = idx_q == (item_q.sides - 1'b1);
	assign pop      = head.valid && (!busy_q || (issue && last_now));
	assign sum_r    = {1'b0, rr_q} + {1'b0, item_q.step_r};
	assign two_n    = {1'b0, item_q.sides, 1'b0};
	assign wrap     = sum_r >= two_n;

	// phase of vertex i is round(i * turn / n), kept as quotient and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (issue && last_now) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
			idx_q  <= '0;
			ph_q   <= '0;
			rr_q   <= {1'b0, head.item.sides};
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
			if (wrap) begin
				rr_q <= ACC_R_W'(sum_r - two_n);
				ph_q <= ph_q + item_q.step_q + 1'b1;
			end else begin
				rr_q <= sum_r[ACC_R_W-1:0];
				ph_q <= ph_q + item_q.step_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= last_now;
			cx_s1   <= item_q.center_x;
			cy_s1   <= item_q.center_y;
			rad_s1  <= item_q.radius;
			sx_s1   <= phase_sine(ph_q);
			sy_s1   <= phase_sine(ph_q + PHASE_W'(QSTEPS));

			last_s2 <= last_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			px_s2   <= PROD_W'(rad_s1) * PROD_W'(sx_s1[LUT_W-1:0]);
			py_s2   <= PROD_W'(rad_s1) * PROD_W'(sy_s1[LUT_W-1:0]);
			nx_s2   <= sx_s1[LUT_W];
			ny_s2   <= sy_s1[LUT_W];

			last_s3 <= last_s2;
			vx_s3   <= place(cx_s2, px_s2, nx_s2);
			vy_s3   <= place(cy_s2, py_s2, ny_s2);
		end
	end

	assign vertex.valid       = vld_s3;
	assign vertex.vertex_x    = vx_s3;
	assign vertex.vertex_y    = vy_s3;
	assign vertex.last_vertex = last_s3;

endmodule

[sv/regular_polygon_vertex_generator_unit.sv]
// top level of the regular polygon vertex generator
//
//   channel  dir  beat contents
//   shape    in   center_x, center_y, side_count, radius
//   vertex   out  vertex_x, vertex_y, last_vertex
//
// front end takes one polygon at a time: accept, step divider, push when the queue has room
// vertex engine emits n vertices for an n-sided polygon (n clamped to 64), one a cycle while
// the vertex channel is not stalled, through registers s1, s2 and s3 after the phase stepper
// zero-sided polygons are dropped in the front end and produce no beats
// reset clears only control state; a stalled vertex beat freezes the vertex engine, while
// the front end keeps filling the two-entry queue
module regular_polygon_vertex_generator_unit import rpvg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rpvg_shape_if.sink    shape,
	rpvg_vertex_if.source vertex
);

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;

	rpvg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.shape  (shape),
		.q_full (q_full),
		.push   (push)
	);

	rpvg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	rpvg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.vertex (vertex)
	);

endmodule

[sv/rpvg_checker.sv]
// port-level checks of the polygon vertex generator and their binding
module rpvg_checker import rpvg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               shape_valid,
	input logic               shape_ready,
	input logic [SIDES_W-1:0] shape_side_count,
	input logic               vertex_valid,
	input logic               vertex_ready,
	input coord_t             vertex_x,
	input coord_t             vertex_y,
	input logic               vertex_last
);

	localparam int BEAT_W = $clog2(MAX_SIDES + 1);

	logic [BEAT_W-1:0] beats_q;
	logic [3:0]        open_q;
	logic              in_beat;
	logic              out_beat;
	logic              open_inc;
	logic              open_dec;

	assign in_beat  = shape_valid && shape_ready;
	assign out_beat = vertex_valid && vertex_ready;
	assign open_inc = in_beat && shape_side_count != '0;
	assign open_dec = out_beat && vertex_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_q <= '0;
			open_q  <= '0;
		end else begin
			if (out_beat) begin
				beats_q <= vertex_last ? '0 : beats_q + 1'b1;
			end
			if (open_inc && !open_dec) begin
				open_q <= open_q + 1'b1;
			end else if (open_dec && !open_inc) begin
				open_q <= open_q - 1'b1;
			end
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=> vertex_valid)
		else $error("vertex beat withdrawn while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=>
		$stable(vertex_x) && $stable(vertex_y) && $stable(vertex_last))
		else $error("vertex payload changed while stalled");

	a_polygon_length: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> beats_q < BEAT_W'(MAX_SIDES))
		else $error("polygon longer than the side limit");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> open_q != '0)
		else $error("vertex beat without an accepted polygon");

endmodule

bind regular_polygon_vertex_generator_unit rpvg_checker u_rpvg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.shape_valid      (shape.valid),
	.shape_ready      (shape.ready),
	.shape_side_count (shape.side_count),
	.vertex_valid     (vertex.valid),
	.vertex_ready     (vertex.ready),
	.vertex_x         (vertex.vertex_x),
	.vertex_y         (vertex.vertex_y),
	.vertex_last      (vertex.last_vertex)
);
